// ===== hw/rtl/wsc_pkg.sv =====
// shared types, widths and constants of the wall sensor conditioner
`timescale 1ns / 1ps

package wsc_pkg;

	// field widths
	localparam int TimeW   = 32;
	localparam int DelayW  = 16;
	localparam int SampleW = 10;
	localparam int IndexW  = 3;
	localparam int DataW   = 16;

	// configuration register indexes
	localparam logic [IndexW-1:0] CFG_DEBOUNCE_TIME     = 3'd0;
	localparam logic [IndexW-1:0] CFG_FRONT_WALL_LEVEL  = 3'd1;
	localparam logic [IndexW-1:0] CFG_FRONT_CLEAR_LEVEL = 3'd2;
	localparam logic [IndexW-1:0] CFG_REAR_WALL_LEVEL   = 3'd3;
	localparam logic [IndexW-1:0] CFG_HIT_WHEN_HIGH     = 3'd4;

	// configuration reset values
	localparam logic [DelayW-1:0]  DEBOUNCE_RESET    = 16'd50;
	localparam logic [SampleW-1:0] FRONT_WALL_RESET  = 10'd600;
	localparam logic [SampleW-1:0] FRONT_CLEAR_RESET = 10'd400;
	localparam logic [SampleW-1:0] REAR_WALL_RESET   = 10'd500;
	localparam logic               HIT_HIGH_RESET    = 1'b0;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [DelayW-1:0]  debounce_time;
		logic [SampleW-1:0] front_wall_level;
		logic [SampleW-1:0] front_clear_level;
		logic [SampleW-1:0] rear_wall_level;
		logic               hit_when_high;
	} cfg_t;

endpackage

// ===== hw/rtl/wsc_cfg.sv =====
// configuration register bank
`timescale 1ns / 1ps

module wsc_cfg
	import wsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [IndexW-1:0] cfg_index,
	input  logic [DataW-1:0]  cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time     <= DEBOUNCE_RESET;
			cfg_q.front_wall_level  <= FRONT_WALL_RESET;
			cfg_q.front_clear_level <= FRONT_CLEAR_RESET;
			cfg_q.rear_wall_level   <= REAR_WALL_RESET;
			cfg_q.hit_when_high     <= HIT_HIGH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_TIME:     cfg_q.debounce_time     <= cfg_data;
				CFG_FRONT_WALL_LEVEL:  cfg_q.front_wall_level  <= cfg_data[SampleW-1:0];
				CFG_FRONT_CLEAR_LEVEL: cfg_q.front_clear_level <= cfg_data[SampleW-1:0];
				CFG_REAR_WALL_LEVEL:   cfg_q.rear_wall_level   <= cfg_data[SampleW-1:0];
				CFG_HIT_WHEN_HIGH:     cfg_q.hit_when_high     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/wsc_debounce.sv =====
// debounce filter for one side switch
`timescale 1ns / 1ps

module wsc_debounce
	import wsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              update,
	input  logic              level,
	input  logic [TimeW-1:0]  now_ms,
	input  logic [DelayW-1:0] debounce_time,
	output logic              stable_next
);

	logic             stable_q;
	logic             previous_q;
	logic [TimeW-1:0] change_time_q;
	logic             changed;
	logic [TimeW-1:0] elapsed;

	// a change restarts the hold time at zero, so the stable level holds
	assign changed     = level != previous_q;
	assign elapsed     = now_ms - change_time_q;
	assign stable_next = (!changed && (elapsed > {{(TimeW-DelayW){1'b0}}, debounce_time}))
		? level : stable_q;

	// filter state moves on with each sample transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b0;
			previous_q    <= 1'b0;
			change_time_q <= '0;
		end else if (update) begin
			stable_q   <= stable_next;
			previous_q <= level;
			if (changed) begin
				change_time_q <= now_ms;
			end
		end
	end

endmodule

// ===== hw/rtl/wsc_photo.sv =====
// front hysteresis flag and rear threshold compare
`timescale 1ns / 1ps

module wsc_photo
	import wsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               update,
	input  logic [SampleW-1:0] front_sample,
	input  logic [SampleW-1:0] rear_sample,
	input  cfg_t               cfg,
	output logic               blocked_next,
	output logic               rear_wall
);

	logic blocked_q;

	// set test wins over clear when the thresholds overlap
	always_comb begin
		if (front_sample >= cfg.front_wall_level) begin
			blocked_next = 1'b1;
		end else if (front_sample <= cfg.front_clear_level) begin
			blocked_next = 1'b0;
		end else begin
			blocked_next = blocked_q;
		end
	end

	assign rear_wall = rear_sample > cfg.rear_wall_level;

	// hysteresis flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= 1'b0;
		end else if (update) begin
			blocked_q <= blocked_next;
		end
	end

endmodule

// ===== hw/rtl/wall_sensor_conditioner.sv =====
// Wall sensor conditioner top level
//
// Takes one sensor sample per transfer on the input channel (in_valid /
// in_stall): a millisecond timestamp, front and rear photodiode readings and
// two raw side switch levels. Gives one result per sample on the output
// channel (out_valid / out_stall): both readings, the front hysteresis flag and
// its inverse, the rear wall compare, the debounced switch levels and hits.
// A sample passes through two registers: the input register, then the compare
// and filter logic into the result register. Throughput is one sample per
// cycle while in_stall is low; the result register frees the input side while a
// finished result waits, and in_stall rises only when both stages are full and
// out_stall is high. A stalled result holds its value.
// Reset clears both stage valids, the switch filters (levels low, change times
// zero), the front flag and loads the configuration defaults. Configuration is
// written through cfg_write / cfg_index / cfg_data; the user must write it only
// while no sample is in flight, unchecked by the block; unknown indexes are ignored.
`timescale 1ns / 1ps

module wall_sensor_conditioner
	import wsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [IndexW-1:0]  cfg_index,
	input  logic [DataW-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [TimeW-1:0]   now_ms,
	input  logic [SampleW-1:0] front_sample,
	input  logic [SampleW-1:0] rear_sample,
	input  logic               left_switch,
	input  logic               right_switch,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SampleW-1:0] front_reading,
	output logic [SampleW-1:0] rear_reading,
	output logic               front_blocked,
	output logic               front_open,
	output logic               rear_wall,
	output logic               left_level,
	output logic               right_level,
	output logic               left_hit,
	output logic               right_hit
);

	cfg_t               cfg;
	logic               valid_s1;
	logic [TimeW-1:0]   now_s1;
	logic [SampleW-1:0] front_s1;
	logic [SampleW-1:0] rear_s1;
	logic               left_s1;
	logic               right_s1;
	logic               valid_s2;
	logic               advance;
	logic               update;
	logic               blocked_next;
	logic               rear_wall_next;
	logic               left_next;
	logic               right_next;

	// stage handshake
	assign advance  = !valid_s2 || !out_stall;
	assign update   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	wsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register, loads whenever the stage is free or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1   <= now_ms;
			front_s1 <= front_sample;
			rear_s1  <= rear_sample;
			left_s1  <= left_switch;
			right_s1 <= right_switch;
		end
	end

	wsc_photo u_photo (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (update),
		.front_sample (front_s1),
		.rear_sample  (rear_s1),
		.cfg          (cfg),
		.blocked_next (blocked_next),
		.rear_wall    (rear_wall_next)
	);

	wsc_debounce u_left (
		.clk           (clk),
		.arst_n        (arst_n),
		.update        (update),
		.level         (left_s1),
		.now_ms        (now_s1),
		.debounce_time (cfg.debounce_time),
		.stable_next   (left_next)
	);

	wsc_debounce u_right (
		.clk           (clk),
		.arst_n        (arst_n),
		.update        (update),
		.level         (right_s1),
		.now_ms        (now_s1),
		.debounce_time (cfg.debounce_time),
		.stable_next   (right_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			front_reading <= front_s1;
			rear_reading  <= rear_s1;
			front_blocked <= blocked_next;
			front_open    <= !blocked_next;
			rear_wall     <= rear_wall_next;
			left_level    <= left_next;
			right_level   <= right_next;
			left_hit      <= left_next == cfg.hit_when_high;
			right_hit     <= right_next == cfg.hit_when_high;
		end
	end

	assign out_valid = valid_s2;

endmodule

// ===== test/wall_sensor_conditioner_tb.sv =====
// testbench of the wall sensor conditioner: sample stimulus, result prediction and checks
`timescale 1ns / 1ps

module wall_sensor_conditioner_tb;
	import wsc_pkg::*;

	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 192;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 100;

	typedef struct packed {
		logic [TimeW-1:0]   now_t;
		logic [SampleW-1:0] front;
		logic [SampleW-1:0] rear;
		logic               left;
		logic               right;
	} sample_t;

	typedef struct packed {
		logic [SampleW-1:0] front_reading;
		logic [SampleW-1:0] rear_reading;
		logic               front_blocked;
		logic               front_open;
		logic               rear_wall;
		logic               left_level;
		logic               right_level;
		logic               left_hit;
		logic               right_hit;
	} result_t;

	// hand-picked samples under the reset settings: threshold edges, debounce edges,
	// time wrap, time going backwards and alternating bit patterns
	localparam sample_t DIRECTED [18] = '{
		'{32'd0,          10'd0,    10'd0,    1'b0, 1'b0},
		'{32'd10,         10'd600,  10'd500,  1'b1, 1'b1},
		'{32'd60,         10'd599,  10'd501,  1'b1, 1'b1},
		'{32'd61,         10'd401,  10'd1023, 1'b1, 1'b1},
		'{32'd62,         10'd400,  10'd0,    1'b0, 1'b1},
		'{32'd62,         10'd1023, 10'd499,  1'b0, 1'b1},
		'{32'd112,        10'd0,    10'd0,    1'b0, 1'b1},
		'{32'd113,        10'd1023, 10'd1023, 1'b0, 1'b0},
		'{32'hFFFF_FFF0,  10'd399,  10'd500,  1'b1, 1'b0},
		'{32'hFFFF_FFFF,  10'd601,  10'd501,  1'b1, 1'b0},
		'{32'h0000_0022,  10'd599,  10'd1,    1'b1, 1'b0},
		'{32'h0000_0023,  10'd599,  10'd1,    1'b1, 1'b1},
		'{32'hAAAA_AAAA,  10'h2AA,  10'h155,  1'b0, 1'b1},
		'{32'h5555_5555,  10'h155,  10'h2AA,  1'b1, 1'b0},
		'{32'hFFFF_FFFF,  10'd1023, 10'd1023, 1'b1, 1'b1},
		'{32'h0000_0000,  10'd0,    10'd0,    1'b0, 1'b0},
		'{32'h0000_0000,  10'd0,    10'd0,    1'b0, 1'b0},
		'{32'h8000_0000,  10'd512,  10'd512,  1'b1, 1'b1}
	};

	// mirror of the conditioner: settings, filter state and the results still owed
	class conditioner_scoreboard;
		cfg_t             cfg;
		bit               blocked;
		bit               left_stable;
		bit               left_prev;
		logic [TimeW-1:0] left_changed_at;
		bit               right_stable;
		bit               right_prev;
		logic [TimeW-1:0] right_changed_at;
		result_t          pending_outputs[$];
		int               mismatch_count;

		function new();
			cfg.debounce_time     = DEBOUNCE_RESET;
			cfg.front_wall_level  = FRONT_WALL_RESET;
			cfg.front_clear_level = FRONT_CLEAR_RESET;
			cfg.rear_wall_level   = REAR_WALL_RESET;
			cfg.hit_when_high     = HIT_HIGH_RESET;
			blocked          = 1'b0;
			left_stable      = 1'b0;
			left_prev        = 1'b0;
			left_changed_at  = '0;
			right_stable     = 1'b0;
			right_prev       = 1'b0;
			right_changed_at = '0;
			mismatch_count   = 0;
		endfunction

		// register write, masked to the register width; unknown indexes do nothing
		function void set_reg(logic [IndexW-1:0] idx, logic [DataW-1:0] data);
			case (idx)
				CFG_DEBOUNCE_TIME:     cfg.debounce_time     = data[DelayW-1:0];
				CFG_FRONT_WALL_LEVEL:  cfg.front_wall_level  = data[SampleW-1:0];
				CFG_FRONT_CLEAR_LEVEL: cfg.front_clear_level = data[SampleW-1:0];
				CFG_REAR_WALL_LEVEL:   cfg.rear_wall_level   = data[SampleW-1:0];
				CFG_HIT_WHEN_HIGH:     cfg.hit_when_high     = data[0];
				default: ;
			endcase
		endfunction

		// one switch filter: a change restarts the hold time, wrapping difference
		function bit debounce(input bit level, input logic [TimeW-1:0] now_t, inout bit prev,
				inout logic [TimeW-1:0] changed_at, inout bit stable_lvl);
			logic [TimeW-1:0] elapsed;
			if (level != prev)
				changed_at = now_t;
			elapsed = now_t - changed_at;
			if (elapsed > TimeW'(cfg.debounce_time))
				stable_lvl = level;
			prev = level;
			return stable_lvl;
		endfunction

		// predict the result of one accepted sample and queue it
		function void note_sample(sample_t s);
			result_t r;
			bit      l_lvl;
			bit      r_lvl;
			// set test first, so overlapping thresholds favor blocked
			if (s.front >= cfg.front_wall_level)
				blocked = 1'b1;
			else if (s.front <= cfg.front_clear_level)
				blocked = 1'b0;
			l_lvl = debounce(s.left, s.now_t, left_prev, left_changed_at, left_stable);
			r_lvl = debounce(s.right, s.now_t, right_prev, right_changed_at, right_stable);
			r.front_reading = s.front;
			r.rear_reading  = s.rear;
			r.front_blocked = blocked;
			r.front_open    = ~blocked;
			r.rear_wall     = (s.rear > cfg.rear_wall_level);
			r.left_level    = l_lvl;
			r.right_level   = r_lvl;
			r.left_hit      = (l_lvl == cfg.hit_when_high);
			r.right_hit     = (r_lvl == cfg.hit_when_high);
			pending_outputs.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
						want, got);
			end
		endfunction

		// compare one result transfer against the oldest prediction
		function void check_result(result_t got);
			result_t want;
			if (pending_outputs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t ns: result with nothing pending, expected none, actual %h",
						$time, got);
			end else begin
				want = pending_outputs.pop_front();
				check_field("front_reading", want.front_reading, got.front_reading);
				check_field("rear_reading", want.rear_reading, got.rear_reading);
				check_field("front_blocked", want.front_blocked, got.front_blocked);
				check_field("front_open", want.front_open, got.front_open);
				check_field("rear_wall", want.rear_wall, got.rear_wall);
				check_field("left_level", want.left_level, got.left_level);
				check_field("right_level", want.right_level, got.right_level);
				check_field("left_hit", want.left_hit, got.left_hit);
				check_field("right_hit", want.right_hit, got.right_hit);
			end
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic [IndexW-1:0]  cfg_index;
	logic [DataW-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [TimeW-1:0]   now_ms;
	logic [SampleW-1:0] front_sample;
	logic [SampleW-1:0] rear_sample;
	logic               left_switch;
	logic               right_switch;
	logic               out_valid;
	logic               out_stall;
	logic [SampleW-1:0] front_reading;
	logic [SampleW-1:0] rear_reading;
	logic               front_blocked;
	logic               front_open;
	logic               rear_wall;
	logic               left_level;
	logic               right_level;
	logic               left_hit;
	logic               right_hit;

	conditioner_scoreboard sb;
	int                    send_idle_pct;
	int                    recv_stall_pct;
	int                    quiet_cycles;
	logic [TimeW-1:0]      cur_now;
	logic                  cur_left;
	logic                  cur_right;

	wall_sensor_conditioner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.front_sample (front_sample),
		.rear_sample  (rear_sample),
		.left_switch  (left_switch),
		.right_switch (right_switch),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.front_reading(front_reading),
		.rear_reading (rear_reading),
		.front_blocked(front_blocked),
		.front_open   (front_open),
		.rear_wall    (rear_wall),
		.left_level   (left_level),
		.right_level  (right_level),
		.left_hit     (left_hit),
		.right_hit    (right_hit)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check each transfer, then pick the stall for the next cycle
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {front_reading, rear_reading, front_blocked, front_open, rear_wall,
					left_level, right_level, left_hit, right_hit};
				sb.check_result(got);
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one sample after a random idle gap and hold it until the transfer
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		now_ms       <= s.now_t;
		front_sample <= s.front;
		rear_sample  <= s.rear;
		left_switch  <= s.left;
		right_switch <= s.right;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	// write enable stays high across back-to-back writes; the caller lowers it
	task automatic write_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// write every register, the narrower ones with junk above their width, plus one unknown index
	task automatic apply_settings(input cfg_t c);
		logic [DataW-1:0] junk;
		junk = DataW'($urandom);
		write_reg(CFG_DEBOUNCE_TIME, c.debounce_time);
		write_reg(CFG_FRONT_WALL_LEVEL, {junk[DataW-1:SampleW], c.front_wall_level});
		write_reg(CFG_HIT_WHEN_HIGH + IndexW'($urandom_range(1, 3)), DataW'($urandom));
		write_reg(CFG_FRONT_CLEAR_LEVEL, {junk[DataW-1:SampleW], c.front_clear_level});
		write_reg(CFG_REAR_WALL_LEVEL, {junk[DataW-1:SampleW], c.rear_wall_level});
		write_reg(CFG_HIT_WHEN_HIGH, {junk[DataW-1:1], c.hit_when_high});
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// settings per phase: extremes and adjacent thresholds first, then random ones
	function automatic cfg_t phase_setting(int p);
		cfg_t c;
		case (p)
			1: begin
				c.debounce_time     = '0;
				c.front_wall_level  = '0;
				c.front_clear_level = '1;
				c.rear_wall_level   = '0;
				c.hit_when_high     = 1'b1;
			end
			2: begin
				c.debounce_time     = '1;
				c.front_wall_level  = '1;
				c.front_clear_level = '0;
				c.rear_wall_level   = '1;
				c.hit_when_high     = 1'b0;
			end
			3: begin
				c.debounce_time     = DelayW'(1);
				c.front_wall_level  = SampleW'(512);
				c.front_clear_level = SampleW'(511);
				c.rear_wall_level   = SampleW'(511);
				c.hit_when_high     = 1'b1;
			end
			default: begin
				c.debounce_time     = DelayW'($urandom_range(300));
				c.front_wall_level  = SampleW'($urandom);
				c.front_clear_level = SampleW'($urandom);
				c.rear_wall_level   = SampleW'($urandom);
				c.hit_when_high     = 1'($urandom);
			end
		endcase
		return c;
	endfunction

	// readings cluster around the thresholds, with extremes and uniform values
	function automatic logic [SampleW-1:0] pick_level(logic [SampleW-1:0] hi_lvl,
			logic [SampleW-1:0] lo_lvl);
		int sel;
		int v;
		sel = $urandom_range(99);
		if (sel < 25)
			v = int'(hi_lvl) + int'($urandom_range(6)) - 3;
		else if (sel < 50)
			v = int'(lo_lvl) + int'($urandom_range(6)) - 3;
		else if (sel < 62)
			v = $urandom_range(1) ? 1023 : 0;
		else
			v = $urandom_range(1023);
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return SampleW'(v);
	endfunction

	initial begin
		sample_t s;
		int      deb;
		int      sel;
		sb = new();
		arst_n         = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		now_ms         = '0;
		front_sample   = '0;
		rear_sample    = '0;
		left_switch    = 1'b0;
		right_switch   = 1'b0;
		out_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		cur_now        = '0;
		cur_left       = 1'b0;
		cur_right      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed samples under the reset settings, no idling
		foreach (DIRECTED[i])
			send_sample(DIRECTED[i]);

		for (int p = 0; p < PHASES; p++) begin
			// idling mode of this phase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			if (p != 0) begin
				in_valid <= 1'b0;
				wait_drained();
				apply_settings(phase_setting(p));
			end
			deb = int'(sb.cfg.debounce_time);
			// some phases start just short of the time wrap
			if (p % 3 == 2)
				cur_now = '1 - TimeW'($urandom_range(4 * deb + 8));

			repeat (PHASE_ITEMS) begin
				// time mostly moves forward around the debounce time, sometimes jumps
				sel = $urandom_range(99);
				if (sel < 50)
					cur_now += TimeW'($urandom_range(deb / 4 + 1));
				else if (sel < 80)
					cur_now += TimeW'(deb + int'($urandom_range(2)) - 1);
				else if (sel < 92)
					cur_now += TimeW'($urandom_range(2 * deb + 2));
				else if (sel < 96)
					cur_now = TimeW'($urandom);
				else
					cur_now -= TimeW'($urandom_range(1, 1000));
				// switches hold most of the time, with bounces
				if ($urandom_range(99) < 20)
					cur_left = ~cur_left;
				if ($urandom_range(99) < 20)
					cur_right = ~cur_right;
				s.now_t = cur_now;
				s.front = pick_level(sb.cfg.front_wall_level, sb.cfg.front_clear_level);
				s.rear  = pick_level(sb.cfg.rear_wall_level, sb.cfg.rear_wall_level);
				s.left  = cur_left;
				s.right = cur_right;
				send_sample(s);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		if (sb.mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/wsc_pkg.sv
hw/rtl/wsc_cfg.sv
hw/rtl/wsc_debounce.sv
hw/rtl/wsc_photo.sv
hw/rtl/wall_sensor_conditioner.sv
test/wall_sensor_conditioner_tb.sv
